/* rtl/core/hpv_pkg.sv */
// Shared types, constants and character-class helpers for the host string validator.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package hpv_pkg;

	localparam int CNT_W     = 9;
	localparam int ACC_W     = 17;
	localparam int PORT_W    = 16;
	localparam int LIMIT_W   = 8;
	localparam int CHAR_W    = 8;

	localparam logic [CNT_W-1:0]   CNT_SAT       = '1;
	localparam logic [ACC_W-1:0]   PORT_SAT      = 17'd65536;
	localparam logic [LIMIT_W-1:0] NAME_LEN_RST  = 8'd253;
	localparam logic [LIMIT_W-1:0] LABEL_LEN_RST = 8'd63;

	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UC_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z   = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;

	typedef enum logic [2:0] {
		RSN_OK         = 3'd0,
		RSN_BAD_FIRST  = 3'd1,
		RSN_NAME_LONG  = 3'd2,
		RSN_BAD_LAST   = 3'd3,
		RSN_LABEL_LONG = 3'd4,
		RSN_LABEL_CHAR = 3'd5,
		RSN_PORT_CHAR  = 3'd6,
		RSN_PORT_RANGE = 3'd7
	} reason_t;

	typedef enum logic [1:0] {
		LERR_NONE = 2'd0,
		LERR_LONG = 2'd1,
		LERR_CHAR = 2'd2
	} label_err_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_byte;
		logic              last_char;
	} beat_t;

	typedef struct packed {
		logic              valid_res;
		reason_t           reason;
		logic              has_port;
		logic [PORT_W-1:0] port_value;
	} result_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return is_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
			((c >= CH_UC_A) && (c <= CH_UC_Z));
	endfunction

endpackage

/* rtl/core/hpv_in_reg.sv */
// Input register stage: captures one byte beat from the slave stream.
// Depends on hpv_pkg.
`timescale 1ns / 1ps

module hpv_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hpv_pkg::CHAR_W-1:0]    s_tdata,
	input  logic                          s_tlast,
	input  logic                          advance,
	output logic                          beat_valid_s1,
	output hpv_pkg::beat_t                beat_s1
);

	assign s_tready = !beat_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			beat_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.char_byte <= s_tdata;
			beat_s1.last_char <= s_tlast;
		end
	end

endmodule

/* rtl/core/hpv_scan.sv */
// Per-string scan state and verdict logic, one beat per cycle unless a final beat waits for the output register.
// Depends on hpv_pkg.
`timescale 1ns / 1ps

module hpv_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          beat_valid_s1,
	input  hpv_pkg::beat_t                beat_s1,
	input  logic                          out_ready,
	input  logic [hpv_pkg::LIMIT_W-1:0]   max_name_len,
	input  logic [hpv_pkg::LIMIT_W-1:0]   max_label_len,
	output logic                          advance,
	output logic                          res_valid,
	output hpv_pkg::result_t              res
);

	logic                        at_start_q, in_port_q, first_bad_q, prev_alnum_q;
	logic                        label_char_bad_q, name_end_bad_q;
	logic                        port_char_bad_q, port_digit_seen_q;
	logic [hpv_pkg::CNT_W-1:0]   name_cnt_q, label_cnt_q;
	hpv_pkg::label_err_t         label_err_q;
	logic [hpv_pkg::ACC_W-1:0]   port_acc_q;

	logic                        fb_d, ip_d, pa_d, lcb_d, neb_d, pcb_d, pds_d;
	logic [hpv_pkg::CNT_W-1:0]   nc_d, lc_d;
	hpv_pkg::label_err_t         le_d;
	logic [hpv_pkg::ACC_W-1:0]   acc_d;
	logic [hpv_pkg::ACC_W+3:0]   acc_mul;
	logic                        c_alnum, c_digit;
	logic [hpv_pkg::CHAR_W-1:0]  c;
	hpv_pkg::reason_t            rsn;

	function automatic hpv_pkg::label_err_t close_label(
		input hpv_pkg::label_err_t      le,
		input logic [hpv_pkg::CNT_W-1:0] cnt,
		input logic                      bad,
		input logic [hpv_pkg::LIMIT_W-1:0] lim
	);
		hpv_pkg::label_err_t r;
		r = le;
		if (le == hpv_pkg::LERR_NONE) begin
			if (cnt > {1'b0, lim})
				r = hpv_pkg::LERR_LONG;
			else if (bad)
				r = hpv_pkg::LERR_CHAR;
		end
		return r;
	endfunction

	assign advance   = beat_valid_s1 && (!beat_s1.last_char || out_ready);
	assign res_valid = advance && beat_s1.last_char;

	assign c       = beat_s1.char_byte;
	assign c_alnum = hpv_pkg::is_alnum(c);
	assign c_digit = hpv_pkg::is_digit(c);
	assign acc_mul = {port_acc_q, 3'b000} + {2'b00, port_acc_q, 1'b0}
		+ {{(hpv_pkg::ACC_W){1'b0}}, c[3:0]};

	always_comb begin
		fb_d  = at_start_q ? !c_alnum : first_bad_q;
		ip_d  = in_port_q;
		pa_d  = prev_alnum_q;
		lcb_d = label_char_bad_q;
		neb_d = name_end_bad_q;
		pcb_d = port_char_bad_q;
		pds_d = port_digit_seen_q;
		nc_d  = name_cnt_q;
		lc_d  = label_cnt_q;
		le_d  = label_err_q;
		acc_d = port_acc_q;
		if (!in_port_q) begin
			if (c == hpv_pkg::CH_COLON) begin
				le_d  = close_label(label_err_q, label_cnt_q, label_char_bad_q, max_label_len);
				lc_d  = '0;
				lcb_d = 1'b0;
				neb_d = !prev_alnum_q;
				ip_d  = 1'b1;
			end else begin
				if (name_cnt_q != hpv_pkg::CNT_SAT)
					nc_d = name_cnt_q + 1'b1;
				if (c == hpv_pkg::CH_DOT) begin
					le_d  = close_label(label_err_q, label_cnt_q, label_char_bad_q,
						max_label_len);
					lc_d  = '0;
					lcb_d = 1'b0;
				end else begin
					if (label_cnt_q != hpv_pkg::CNT_SAT)
						lc_d = label_cnt_q + 1'b1;
					if (!(c_alnum || c == hpv_pkg::CH_HYPHEN))
						lcb_d = 1'b1;
				end
				pa_d = c_alnum;
			end
		end else begin
			if (c_digit) begin
				if (acc_mul > {4'b0000, hpv_pkg::PORT_SAT})
					acc_d = hpv_pkg::PORT_SAT;
				else
					acc_d = acc_mul[hpv_pkg::ACC_W-1:0];
				pds_d = 1'b1;
			end else begin
				pcb_d = 1'b1;
			end
		end
		if (!ip_d && beat_s1.last_char) begin
			le_d  = close_label(le_d, lc_d, lcb_d, max_label_len);
			neb_d = !pa_d;
		end

		if (fb_d)
			rsn = hpv_pkg::RSN_BAD_FIRST;
		else if (nc_d > {1'b0, max_name_len})
			rsn = hpv_pkg::RSN_NAME_LONG;
		else if (neb_d)
			rsn = hpv_pkg::RSN_BAD_LAST;
		else if (le_d == hpv_pkg::LERR_LONG)
			rsn = hpv_pkg::RSN_LABEL_LONG;
		else if (le_d == hpv_pkg::LERR_CHAR)
			rsn = hpv_pkg::RSN_LABEL_CHAR;
		else if (ip_d && (pcb_d || !pds_d))
			rsn = hpv_pkg::RSN_PORT_CHAR;
		else if (ip_d && (acc_d == '0 || acc_d >= hpv_pkg::PORT_SAT))
			rsn = hpv_pkg::RSN_PORT_RANGE;
		else
			rsn = hpv_pkg::RSN_OK;

		res.valid_res  = (rsn == hpv_pkg::RSN_OK);
		res.reason     = rsn;
		res.has_port   = ip_d;
		res.port_value = (res.valid_res && ip_d) ? acc_d[hpv_pkg::PORT_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q        <= 1'b1;
			in_port_q         <= 1'b0;
			first_bad_q       <= 1'b0;
			prev_alnum_q      <= 1'b0;
			label_char_bad_q  <= 1'b0;
			name_end_bad_q    <= 1'b0;
			port_char_bad_q   <= 1'b0;
			port_digit_seen_q <= 1'b0;
			name_cnt_q        <= '0;
			label_cnt_q       <= '0;
			label_err_q       <= hpv_pkg::LERR_NONE;
			port_acc_q        <= '0;
		end else if (advance) begin
			if (beat_s1.last_char) begin
				at_start_q        <= 1'b1;
				in_port_q         <= 1'b0;
				first_bad_q       <= 1'b0;
				prev_alnum_q      <= 1'b0;
				label_char_bad_q  <= 1'b0;
				name_end_bad_q    <= 1'b0;
				port_char_bad_q   <= 1'b0;
				port_digit_seen_q <= 1'b0;
				name_cnt_q        <= '0;
				label_cnt_q       <= '0;
				label_err_q       <= hpv_pkg::LERR_NONE;
				port_acc_q        <= '0;
			end else begin
				at_start_q        <= 1'b0;
				in_port_q         <= ip_d;
				first_bad_q       <= fb_d;
				prev_alnum_q      <= pa_d;
				label_char_bad_q  <= lcb_d;
				name_end_bad_q    <= neb_d;
				port_char_bad_q   <= pcb_d;
				port_digit_seen_q <= pds_d;
				name_cnt_q        <= nc_d;
				label_cnt_q       <= lc_d;
				label_err_q       <= le_d;
				port_acc_q        <= acc_d;
			end
		end
	end

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		port_acc_q <= hpv_pkg::PORT_SAT)
		else $error("port accumulator above saturation");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (at_start_q && !in_port_q && name_cnt_q == '0))
		else $error("state not cleared after final beat");

	a_port_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.port_value != '0) |-> (res.valid_res && res.has_port))
		else $error("port value on failing or portless result");

	a_first_bad_start: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !beat_s1.last_char) |=> !at_start_q)
		else $error("start flag kept after a non-final beat");

endmodule

/* rtl/core/hpv_out_reg.sv */
// Output register stage: holds one result beat for the master stream.
// Depends on hpv_pkg.
`timescale 1ns / 1ps

module hpv_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  hpv_pkg::result_t    res,
	output logic                out_ready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output hpv_pkg::result_t    res_q
);

	assign out_ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_ready) begin
			res_q <= res;
		end
	end

endmodule

/* rtl/core/hostname_port_validator.sv */
// Top level of the host string validator: APB limit registers and the stream datapath.
// Depends on hpv_pkg, hpv_in_reg, hpv_scan, hpv_out_reg.
`timescale 1ns / 1ps

// Checks a hostname with an optional ":port" suffix, one byte beat per clock while the output
// side is not backed up; each string yields a single result beat, presented on the master
// side after its tlast byte is accepted and passes the input register, then the result register,
// and bytes of the next string keep flowing while that result waits, up to that string's
// own tlast byte. Result: valid flag, reason code (0 ok,
// 1 bad first byte, 2 name too long, 3 bad last name byte, 4 label too long, 5 bad label
// byte, 6 bad or empty port, 7 port out of range), colon seen, and the port (0 unless
// valid). Limits sit at 0x0 (name, reset 253) and 0x4 (label, reset 63); write them only
// while idle.

module hostname_port_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] valid_res, [3:1] reason, [4] has_port,
	                               // [20:5] port_value, [23:21] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [hpv_pkg::LIMIT_W-1:0] max_name_len_q, max_label_len_q;
	logic                        advance, beat_valid_s1, res_valid, out_ready;
	hpv_pkg::beat_t              beat_s1;
	hpv_pkg::result_t            res, res_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q  <= hpv_pkg::NAME_LEN_RST;
			max_label_len_q <= hpv_pkg::LABEL_LEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2])
				max_label_len_q <= pwdata[hpv_pkg::LIMIT_W-1:0];
			else
				max_name_len_q <= pwdata[hpv_pkg::LIMIT_W-1:0];
		end
	end

	assign prdata = paddr[2] ? {24'd0, max_label_len_q} : {24'd0, max_name_len_q};

	hpv_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.advance       (advance),
		.beat_valid_s1 (beat_valid_s1),
		.beat_s1       (beat_s1)
	);

	hpv_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_valid_s1 (beat_valid_s1),
		.beat_s1       (beat_s1),
		.out_ready     (out_ready),
		.max_name_len  (max_name_len_q),
		.max_label_len (max_label_len_q),
		.advance       (advance),
		.res_valid     (res_valid),
		.res           (res)
	);

	hpv_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {3'b000, res_q.port_value, res_q.has_port, res_q.reason, res_q.valid_res};

endmodule

/* tb/tb_hostname_port_validator.sv */
// Self-checking testbench for hostname_port_validator: byte stream in, verdict beats out.
// Depends on hpv_pkg and the RTL under rtl/core; limit registers are set over APB.
`timescale 1ns / 1ps

module tb_hostname_port_validator;
	import hpv_pkg::*;

	localparam logic [2:0] ADDR_NAME_LIMIT  = 3'd0;
	localparam logic [2:0] ADDR_LABEL_LIMIT = 3'd4;
	localparam int         LONG_HOLD        = 300;
	localparam int         HOLD_AT_RESULT   = 11;
	localparam int         HOLD_MIN_PENDING = 24;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hostname_port_validator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	beat_t       host_bytes_q[$];
	logic [7:0]  spell_q[$];
	result_t     verdict_q[$];
	int          queued;
	int          err_count;
	int          results_seen;
	bit          byte_taken;
	bit          quiet;
	int          send_gap;
	int          hold_left;
	bit          long_hold_done;

	// scanner copy: limits and per-string state
	logic [7:0]       lim_name;
	logic [7:0]       lim_label;
	bit               at_start;
	bit               in_port;
	bit               first_bad;
	logic [CNT_W-1:0] name_cnt;
	logic [CNT_W-1:0] label_cnt;
	bit               prev_alnum;
	bit               label_bad_char;
	label_err_t       label_err;
	bit               name_end_bad;
	logic [ACC_W-1:0] port_acc;
	bit               port_bad;
	bit               port_digit;

	function automatic bit digit_byte(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit letter_or_digit(input logic [7:0] c);
		return digit_byte(c) || (c >= CH_UC_A && c <= CH_UC_Z) ||
			(c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function automatic void clear_scan();
		at_start       = 1'b1;
		in_port        = 1'b0;
		first_bad      = 1'b0;
		name_cnt       = '0;
		label_cnt      = '0;
		prev_alnum     = 1'b0;
		label_bad_char = 1'b0;
		label_err      = LERR_NONE;
		name_end_bad   = 1'b0;
		port_acc       = '0;
		port_bad       = 1'b0;
		port_digit     = 1'b0;
	endfunction

	// only the earliest failing label is kept
	function automatic void end_label();
		if (label_err == LERR_NONE) begin
			if (label_cnt > {1'b0, lim_label})
				label_err = LERR_LONG;
			else if (label_bad_char)
				label_err = LERR_CHAR;
		end
		label_cnt      = '0;
		label_bad_char = 1'b0;
	endfunction

	task automatic scan_host_byte(input logic [7:0] c, input logic fin, output bit done,
			output result_t v);
		reason_t why;
		int      acc;
		bit      an;
		an   = letter_or_digit(c);
		done = 1'b0;
		v    = '0;
		if (at_start) begin
			first_bad = !an;
			at_start  = 1'b0;
		end
		if (!in_port) begin
			if (c == CH_COLON) begin
				end_label();
				name_end_bad = !prev_alnum;
				in_port      = 1'b1;
			end else begin
				if (name_cnt != CNT_SAT)
					name_cnt++;
				if (c == CH_DOT) begin
					end_label();
				end else begin
					if (label_cnt != CNT_SAT)
						label_cnt++;
					if (!an && c != CH_HYPHEN)
						label_bad_char = 1'b1;
				end
				prev_alnum = an;
			end
		end else if (digit_byte(c)) begin
			acc        = int'(port_acc) * 10 + int'(c - CH_ZERO);
			port_acc   = (acc > int'(PORT_SAT)) ? PORT_SAT : acc[ACC_W-1:0];
			port_digit = 1'b1;
		end else begin
			port_bad = 1'b1;
		end
		if (fin) begin
			if (!in_port) begin
				end_label();
				name_end_bad = !prev_alnum;
			end
			if (first_bad)
				why = RSN_BAD_FIRST;
			else if (name_cnt > {1'b0, lim_name})
				why = RSN_NAME_LONG;
			else if (name_end_bad)
				why = RSN_BAD_LAST;
			else if (label_err == LERR_LONG)
				why = RSN_LABEL_LONG;
			else if (label_err == LERR_CHAR)
				why = RSN_LABEL_CHAR;
			else if (in_port && (port_bad || !port_digit))
				why = RSN_PORT_CHAR;
			else if (in_port && (port_acc == '0 || port_acc >= PORT_SAT))
				why = RSN_PORT_RANGE;
			else
				why = RSN_OK;
			v.valid_res  = (why == RSN_OK);
			v.reason     = why;
			v.has_port   = in_port;
			v.port_value = (why == RSN_OK && in_port) ? port_acc[PORT_W-1:0] : '0;
			done         = 1'b1;
			clear_scan();
		end
	endtask

	task automatic log_fault(input string msg);
		if (err_count < 10)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// input side: keeps tvalid up until the beat is taken
	always @(negedge clk) begin : drive_bytes
		beat_t bt;
		bit    busy;
		if (arst_n) begin
			busy = s_tvalid && !byte_taken;
			if (s_tvalid && byte_taken)
				void'(host_bytes_q.pop_front());
			if (!busy) begin
				if (send_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 6);
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (host_bytes_q.size() > 0) begin
					bt = host_bytes_q[0];
					s_tvalid <= 1'b1;
					s_tdata  <= bt.char_byte;
					s_tlast  <= bt.last_char;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: short random stalls, one long hold-off to back up the input
	always @(negedge clk) begin : drain_results
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= HOLD_AT_RESULT &&
					host_bytes_q.size() >= HOLD_MIN_PENDING) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		bit      got;
		result_t v;
		result_t want;
		byte_taken = arst_n && s_tvalid && s_tready;
		if (byte_taken) begin
			scan_host_byte(s_tdata, s_tlast, got, v);
			if (got)
				verdict_q = {verdict_q, v};
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (verdict_q.size() == 0) begin
				log_fault($sformatf("unexpected result beat %h", m_tdata));
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata !== {3'b000, want.port_value, want.has_port, want.reason,
						want.valid_res})
					log_fault($sformatf({"valid %0d/%0d reason %0d/%0d port_seen %0d/%0d ",
						"port %0d/%0d pad %0d (exp/act)"},
						want.valid_res, m_tdata[0], want.reason, m_tdata[3:1],
						want.has_port, m_tdata[4], want.port_value, m_tdata[20:5],
						m_tdata[23:21]));
			end
		end
	end

	task automatic push_byte(input logic [7:0] c, input logic fin);
		beat_t bt;
		bt.char_byte = c;
		bt.last_char = fin;
		host_bytes_q = {host_bytes_q, bt};
		queued++;
	endtask

	task automatic spell_add(input logic [7:0] ch);
		spell_q = {spell_q, ch};
	endtask

	task automatic flush_host();
		int k;
		if (spell_q.size() == 0)
			spell_add(CH_LC_A);
		for (k = 0; k < spell_q.size(); k++)
			push_byte(spell_q[k], k == spell_q.size() - 1);
		spell_q.delete();
	endtask

	task automatic push_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			spell_add(s[k]);
		flush_host();
	endtask

	function automatic logic [7:0] alnum_pick();
		case ($urandom_range(0, 2))
			0: return CH_ZERO + 8'($urandom_range(0, 9));
			1: return CH_LC_A + 8'($urandom_range(0, 25));
			default: return CH_UC_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] label_pick(input bit rim);
		if ($urandom_range(0, 29) == 0)
			return 8'($urandom_range(0, 255));
		else if (!rim && $urandom_range(0, 5) == 0)
			return CH_HYPHEN;
		else
			return alnum_pick();
	endfunction

	task automatic add_port();
		int    v;
		int    k;
		int    zeros;
		int    junk_at;
		string digits;
		spell_add(CH_COLON);
		junk_at = -1;
		zeros   = 0;
		case ($urandom_range(0, 9))
			0: return;
			1: v = 0;
			2: v = $urandom_range(60000, 9999999);
			3: v = 65534 + $urandom_range(0, 3);
			4: begin
				v       = $urandom_range(1, 65535);
				junk_at = 0;
			end
			default: v = $urandom_range(1, 65535);
		endcase
		if ($urandom_range(0, 3) == 0)
			zeros = $urandom_range(1, 3);
		digits = $sformatf("%0d", v);
		if (junk_at == 0)
			junk_at = $urandom_range(0, digits.len());
		for (k = 0; k < zeros; k++)
			spell_add(CH_ZERO);
		for (k = 0; k <= digits.len(); k++) begin
			if (k == junk_at)
				spell_add(($urandom_range(0, 1) == 0) ? CH_COLON :
					8'($urandom_range(0, 255)));
			if (k < digits.len())
				spell_add(digits[k]);
		end
	endtask

	task automatic gen_host();
		int len;
		int labels;
		int j;
		int k;
		if ($urandom_range(0, 9) >= 8) begin
			len = $urandom_range(1, 10);
			for (k = 0; k < len; k++)
				case ($urandom_range(0, 3))
					0: spell_add(8'($urandom_range(0, 255)));
					1: spell_add(CH_COLON);
					2: spell_add(CH_DOT);
					default: spell_add(alnum_pick());
				endcase
		end else begin
			labels = $urandom_range(1, 4);
			for (j = 0; j < labels; j++) begin
				if (j > 0)
					spell_add(CH_DOT);
				len = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 70) :
					$urandom_range(0, 7);
				for (k = 0; k < len; k++)
					spell_add(label_pick(k == 0 || k == len - 1));
			end
			if ($urandom_range(0, 14) == 0)
				spell_add(CH_HYPHEN);
			if ($urandom_range(0, 1) == 0)
				add_port();
		end
		flush_host();
	endtask

	task automatic random_hosts(input int n);
		int stop_at;
		stop_at = queued + n;
		while (queued < stop_at)
			gen_host();
	endtask

	// idle point: everything sent and answered, followed by an idle wait on the clock
	task automatic settle();
		while (host_bytes_q.size() != 0 || verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limit(input logic [2:0] addr, input logic [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_NAME_LIMIT)
			lim_name = val;
		else
			lim_label = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[7:0] !== val)
			log_fault($sformatf("readback at %0d: exp %0d act %0d", addr, val, prdata[7:0]));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_limits(input logic [7:0] name_lim, input logic [7:0] label_lim);
		set_limit(ADDR_NAME_LIMIT, name_lim);
		set_limit(ADDR_LABEL_LIMIT, label_lim);
	endtask

	initial begin : run_phases
		int k;
		int ph;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		queued         = 0;
		err_count      = 0;
		results_seen   = 0;
		byte_taken     = 1'b0;
		quiet          = 1'b0;
		send_gap       = 0;
		hold_left      = 0;
		long_hold_done = 1'b0;
		lim_name       = NAME_LEN_RST;
		lim_label      = LABEL_LEN_RST;
		clear_scan();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limits: byte extremes, empty labels, bad edges, port corner cases
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_text("a");
		push_text("a..b");
		push_text("a-");
		spell_add(CH_LC_A);
		spell_add(8'h80);
		spell_add(CH_LC_A + 8'd1);
		flush_host();
		push_text("a:");
		push_text("a::1");
		push_text("a:0");
		push_text("a:65536");
		settle();

		// widest limits; one run long enough to hit counter saturation
		set_limits(8'd255, 8'd255);
		for (k = 0; k < 515; k++)
			spell_add(alnum_pick());
		flush_host();
		random_hosts(40);
		settle();

		set_limits(8'd1, 8'd1);
		random_hosts(25);
		settle();

		set_limits(8'd0, 8'd0);
		random_hosts(15);
		settle();

		for (ph = 0; ph < 3; ph++) begin
			set_limits(8'($urandom_range(2, 40)), 8'($urandom_range(1, 10)));
			random_hosts(10);
			settle();
		end

		set_limits(NAME_LEN_RST, LABEL_LEN_RST);
		quiet = 1'b1;
		random_hosts(25);
		settle();

		if (err_count == 0)
			$display("tb_hostname_port_validator: clean");
		else
			$display("tb_hostname_port_validator: errors");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb_hostname_port_validator: errors");
		$finish;
	end

endmodule
